// ===== rtl/core/tsw_pkg.sv =====
// shared types, codes and constants for the tcp sender window engine
package tsw_pkg;

  localparam int MAX_PAYLOAD_DEF = 1452;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int MAX_RESULTS     = 48;

  localparam logic [2:0] REQ_ACK    = 3'd0;
  localparam logic [2:0] REQ_TICK   = 3'd1;
  localparam logic [2:0] REQ_FILL   = 3'd2;
  localparam logic [2:0] REQ_APPEND = 3'd3;
  localparam logic [2:0] REQ_END    = 3'd4;
  localparam logic [2:0] REQ_EMPTY  = 3'd5;

  localparam logic [1:0] CFG_ISN = 2'd0;
  localparam logic [1:0] CFG_RTO = 2'd1;
  localparam logic [1:0] CFG_CAP = 2'd2;

  localparam logic [15:0] RTO_RESET = 16'd1000;
  localparam logic [31:0] CAP_RESET = 32'd65536;

  typedef enum logic [2:0] {
    K_ACK, K_TICK, K_FILL, K_APPEND, K_END, K_EMPTY, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] ack_number;
    logic [15:0] receive_window;
    logic [15:0] elapsed_ms;
    logic [15:0] append_count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] len;
    logic        syn;
    logic        fin;
  } qinfo_t;

  typedef struct packed {
    logic        segment_valid;
    logic [31:0] segment_seqno;
    logic [31:0] payload_offset;
    logic [10:0] payload_length;
    logic        syn_bit;
    logic        fin_bit;
    logic        is_retransmission;
    logic [31:0] in_flight_bytes;
    logic [15:0] retransmit_count;
    logic [15:0] accepted_count;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [10:0] queue_count;
    logic        busy;
  } stat_t;

endpackage

// ===== rtl/core/tsw_front.sv =====
// front end: takes request words, decodes the request kind and queues them
module tsw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_req_type,
  input  logic [31:0]   in_ack_number,
  input  logic [15:0]   in_receive_window,
  input  logic [15:0]   in_elapsed_ms,
  input  logic [15:0]   in_append_count,
  output logic          cmd_valid,
  output tsw_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import tsw_pkg::*;

  cmd_t       fifo_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.ack_number     = in_ack_number;
    dec.receive_window = in_receive_window;
    dec.elapsed_ms     = in_elapsed_ms;
    dec.append_count   = in_append_count;
    unique case (in_req_type)
      REQ_ACK:    dec.kind = K_ACK;
      REQ_TICK:   dec.kind = K_TICK;
      REQ_FILL:   dec.kind = K_FILL;
      REQ_APPEND: dec.kind = K_APPEND;
      REQ_END:    dec.kind = K_END;
      REQ_EMPTY:  dec.kind = K_EMPTY;
      default:    dec.kind = K_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = cmd_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/core/tsw_engine.sv =====
// back end: sequencer for all request kinds, with the outstanding segment queue
module tsw_engine #(
  parameter int MAX_PAYLOAD = tsw_pkg::MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  input  logic           cmd_valid,
  input  tsw_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output tsw_pkg::res_t  out_res,
  output tsw_pkg::stat_t stat
);
  import tsw_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] MAXP = 16'(MAX_PAYLOAD);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_LOAD   = 12'b000000000010,
    S_ACMP   = 12'b000000000100,
    S_RCHK   = 12'b000000001000,
    S_RWAIT  = 12'b000000010000,
    S_AWIN   = 12'b000000100000,
    S_FILL   = 12'b000001000000,
    S_FDATA  = 12'b000010000000,
    S_FTIMER = 12'b000100000000,
    S_TICK   = 12'b001000000000,
    S_EMIT   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t      state_r, state_nxt, ret_r, ret_nxt;
  logic [31:0] isn_r;
  logic [15:0] rto_r;
  logic [31:0] cap_r;
  logic [63:0] next_r, next_nxt;
  logic [63:0] acked_r, acked_nxt;
  logic [15:0] win_r, win_nxt;
  logic        fin_sent_r, fin_sent_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] timeout_r, timeout_nxt;
  logic        running_r, running_nxt;
  logic        zws_r, zws_nxt;
  logic [15:0] retx_r, retx_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic        ended_r, ended_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] qcount_r, qcount_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [63:0] a_r, a_nxt;
  logic [5:0]  nres_r, nres_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [63:0] seg_start_r, seg_start_nxt;
  logic [31:0] seg_off_r, seg_off_nxt;
  logic [15:0] seg_len_r, seg_len_nxt;
  logic        seg_syn_r, seg_syn_nxt;
  logic        seg_fin_r, seg_fin_nxt;
  logic        seg_retx_r, seg_retx_nxt;
  res_t        pend_r, pend_nxt;
  logic        pend_v_r, pend_v_nxt;
  res_t        out_r, out_nxt;
  logic        out_v_r, out_v_nxt;

  logic [63:0] start_mem [QUEUE_DEPTH];
  qinfo_t      info_mem [QUEUE_DEPTH];
  logic [63:0] rd_start_q;
  qinfo_t      rd_info_q;
  logic        mem_we;
  logic [63:0] wr_start;
  qinfo_t      wr_info;

  logic [63:0] diff64;
  logic [31:0] infl;
  logic        out_free;
  logic        can_push;
  logic [16:0] head_span;
  logic [QW-1:0] head_inc, tail_inc;
  res_t        new_res, stat_res, final_res;
  logic [31:0] unw_off, unw_d;
  logic [31:0] unw_hi;
  logic [15:0] n;
  logic [31:0] buf_after, room, ms_sum;
  logic [15:0] win_after;
  logic        fin_now;
  logic [63:0] ack_lim;

  assign diff64   = next_r - acked_r;
  assign infl     = (next_r < acked_r) ? 32'd0 :
                    (diff64[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff64[31:0];
  assign out_free = !out_v_r || !out_stall;
  assign can_push = (qcount_r < CW'(QUEUE_DEPTH)) && (nres_r < 6'(MAX_RESULTS));
  assign head_span = {1'b0, rd_info_q.len} + {16'd0, rd_info_q.syn} + {16'd0, rd_info_q.fin};
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign stat.queue_count = 11'(qcount_r);
  assign stat.busy        = (state_r != S_IDLE);

  always_comb begin
    new_res.segment_valid     = 1'b1;
    new_res.segment_seqno     = seg_start_r[31:0] + isn_r;
    new_res.payload_offset    = seg_off_r;
    new_res.payload_length    = seg_len_r[10:0];
    new_res.syn_bit           = seg_syn_r;
    new_res.fin_bit           = seg_fin_r;
    new_res.is_retransmission = seg_retx_r;
    new_res.in_flight_bytes   = infl;
    new_res.retransmit_count  = retx_r;
    new_res.accepted_count    = 16'd0;
    new_res.last_result       = 1'b0;
    stat_res                  = '0;
    stat_res.in_flight_bytes  = infl;
    stat_res.retransmit_count = retx_r;
    stat_res.accepted_count   = acc_r;
    final_res                 = pend_v_r ? pend_r : stat_res;
    final_res.last_result     = 1'b1;
  end

  // ack unwrap against acked_r
  always_comb begin
    unw_off = cmd_r.ack_number - isn_r;
    unw_hi  = acked_r[63:32];
    if (unw_off > acked_r[31:0]) begin
      unw_d = unw_off - acked_r[31:0];
      if (unw_d > 32'h8000_0000 && unw_hi != 32'd0) begin
        unw_hi = unw_hi - 32'd1;
      end
    end else begin
      unw_d = acked_r[31:0] - unw_off;
      if (unw_d > 32'h8000_0000 && unw_hi != 32'hFFFF_FFFF) begin
        unw_hi = unw_hi + 32'd1;
      end
    end
  end

  // data segment sizing, append room, tick time sum and ack retire limit
  always_comb begin
    n = (buf_r < {16'd0, win_r}) ? buf_r[15:0] : win_r;
    if (n > MAXP) begin
      n = MAXP;
    end
    buf_after = buf_r - {16'd0, n};
    win_after = win_r - n;
    fin_now   = ended_r && (buf_after == 32'd0) && (win_after != 16'd0);
    room      = (cap_r > buf_r) ? cap_r - buf_r : 32'd0;
    ms_sum    = elapsed_r + {16'd0, cmd_r.elapsed_ms};
    ack_lim   = acked_r + {47'd0, head_span};
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    next_nxt      = next_r;
    acked_nxt     = acked_r;
    win_nxt       = win_r;
    fin_sent_nxt  = fin_sent_r;
    elapsed_nxt   = elapsed_r;
    timeout_nxt   = timeout_r;
    running_nxt   = running_r;
    zws_nxt       = zws_r;
    retx_nxt      = retx_r;
    buf_nxt       = buf_r;
    ended_nxt     = ended_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    qcount_nxt    = qcount_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    nres_nxt      = nres_r;
    acc_nxt       = acc_r;
    seg_start_nxt = seg_start_r;
    seg_off_nxt   = seg_off_r;
    seg_len_nxt   = seg_len_r;
    seg_syn_nxt   = seg_syn_r;
    seg_fin_nxt   = seg_fin_r;
    seg_retx_nxt  = seg_retx_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_v_nxt     = out_v_r && out_stall;
    mem_we        = 1'b0;
    wr_start      = seg_start_nxt;
    wr_info.len   = 16'd0;
    wr_info.syn   = 1'b0;
    wr_info.fin   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          nres_nxt   = 6'd0;
          acc_nxt    = 16'd0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        unique case (cmd_r.kind)
          K_ACK: begin
            a_nxt     = {unw_hi, unw_off};
            state_nxt = S_ACMP;
          end
          K_TICK: begin
            elapsed_nxt = (ms_sum < elapsed_r) ? 32'hFFFF_FFFF : ms_sum;
            state_nxt   = S_TICK;
          end
          K_FILL: state_nxt = S_FILL;
          K_APPEND: begin
            if (!ended_r) begin
              acc_nxt = ({16'd0, cmd_r.append_count} < room) ? cmd_r.append_count : room[15:0];
              buf_nxt = buf_r + {16'd0, acc_nxt};
            end
            state_nxt = S_DONE;
          end
          K_END: begin
            ended_nxt = 1'b1;
            state_nxt = S_DONE;
          end
          K_EMPTY: begin
            seg_start_nxt = next_r;
            seg_off_nxt   = (next_r == 64'd0) ? 32'd0 :
                            next_r[31:0] - 32'd1 - {31'd0, fin_sent_r};
            seg_len_nxt   = 16'd0;
            seg_syn_nxt   = 1'b0;
            seg_fin_nxt   = 1'b0;
            seg_retx_nxt  = 1'b0;
            ret_nxt       = S_DONE;
            state_nxt     = S_EMIT;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ACMP: begin
        if (a_r > next_r) begin
          state_nxt = S_DONE;
        end else if (acked_r == 64'd0 && a_r == 64'd1) begin
          acked_nxt = 64'd1;
          if (qcount_r != '0) begin
            head_nxt   = head_inc;
            qcount_nxt = qcount_r - 1'b1;
          end
          retx_nxt  = 16'd0;
          state_nxt = S_AWIN;
        end else if (qcount_r != '0 && a_r >= ack_lim) begin
          timeout_nxt = {16'd0, rto_r};
          elapsed_nxt = 32'd0;
          retx_nxt    = 16'd0;
          state_nxt   = S_RCHK;
        end else if (a_r == next_r && fin_sent_r) begin
          acked_nxt = a_r;
          if (qcount_r != '0) begin
            head_nxt   = head_inc;
            qcount_nxt = qcount_r - 1'b1;
          end
          state_nxt = S_AWIN;
        end else begin
          state_nxt = S_AWIN;
        end
      end
      S_RCHK: begin
        if (rd_start_q + {47'd0, head_span} <= a_r) begin
          acked_nxt  = ack_lim;
          head_nxt   = head_inc;
          qcount_nxt = qcount_r - 1'b1;
          state_nxt  = (qcount_r == CW'(1)) ? S_AWIN : S_RWAIT;
        end else begin
          state_nxt = S_AWIN;
        end
      end
      S_RWAIT: state_nxt = S_RCHK;
      S_AWIN: begin
        if (diff64 == 64'd0) begin
          running_nxt = 1'b0;
        end
        if (diff64 != 64'd0 && diff64 >= {48'd0, cmd_r.receive_window}) begin
          win_nxt   = 16'd0;
          state_nxt = S_DONE;
        end else begin
          if (cmd_r.receive_window == 16'd0) begin
            win_nxt = 16'd1;
            zws_nxt = 1'b1;
          end else begin
            win_nxt  = cmd_r.receive_window;
            zws_nxt  = 1'b0;
            retx_nxt = 16'd0;
          end
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        seg_retx_nxt = 1'b0;
        if (win_r == 16'd0 || fin_sent_r) begin
          state_nxt = S_DONE;
        end else if (next_r == 64'd0) begin
          state_nxt = S_FTIMER;
          if (can_push) begin
            next_nxt      = 64'd1;
            win_nxt       = win_r - 16'd1;
            seg_start_nxt = 64'd0;
            seg_off_nxt   = 32'd0;
            seg_len_nxt   = 16'd0;
            seg_syn_nxt   = 1'b1;
            seg_fin_nxt   = 1'b0;
            ret_nxt       = S_FTIMER;
            state_nxt     = S_EMIT;
          end
        end else if (ended_r && buf_r == 32'd0) begin
          state_nxt = S_FTIMER;
          if (can_push) begin
            fin_sent_nxt  = 1'b1;
            next_nxt      = next_r + 64'd1;
            win_nxt       = win_r - 16'd1;
            seg_start_nxt = next_r;
            seg_off_nxt   = next_r[31:0] - 32'd1;
            seg_len_nxt   = 16'd0;
            seg_syn_nxt   = 1'b0;
            seg_fin_nxt   = 1'b1;
            ret_nxt       = S_FTIMER;
            state_nxt     = S_EMIT;
          end
        end else begin
          state_nxt = S_FDATA;
        end
        if (state_nxt == S_EMIT) begin
          mem_we      = 1'b1;
          wr_start    = seg_start_nxt;
          wr_info.len = seg_len_nxt;
          wr_info.syn = seg_syn_nxt;
          wr_info.fin = seg_fin_nxt;
          tail_nxt    = tail_inc;
          qcount_nxt  = qcount_r + 1'b1;
        end
      end
      S_FDATA: begin
        if (buf_r != 32'd0 && win_r != 16'd0 && can_push) begin
          buf_nxt       = buf_after;
          win_nxt       = win_after - {15'd0, fin_now};
          next_nxt      = next_r + {48'd0, n} + {63'd0, fin_now};
          if (fin_now) begin
            fin_sent_nxt = 1'b1;
          end
          seg_start_nxt = next_r;
          seg_off_nxt   = (next_r == 64'd0) ? 32'd0 : next_r[31:0] - 32'd1;
          seg_len_nxt   = n;
          seg_syn_nxt   = 1'b0;
          seg_fin_nxt   = fin_now;
          seg_retx_nxt  = 1'b0;
          mem_we        = 1'b1;
          wr_start      = next_r;
          wr_info.len   = n;
          wr_info.fin   = fin_now;
          tail_nxt      = tail_inc;
          qcount_nxt    = qcount_r + 1'b1;
          ret_nxt       = fin_now ? S_FTIMER : S_FDATA;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_FTIMER;
        end
      end
      S_FTIMER: begin
        if (!running_r) begin
          timeout_nxt = {16'd0, rto_r};
          running_nxt = 1'b1;
          elapsed_nxt = 32'd0;
        end
        state_nxt = S_DONE;
      end
      S_TICK: begin
        if (qcount_r != '0 && running_r && elapsed_r >= timeout_r) begin
          if (retx_r != 16'hFFFF) begin
            retx_nxt = retx_r + 16'd1;
          end
          if (!zws_r) begin
            timeout_nxt = timeout_r[31] ? 32'hFFFF_FFFF : {timeout_r[30:0], 1'b0};
          end
          elapsed_nxt   = 32'd0;
          seg_start_nxt = rd_start_q;
          seg_off_nxt   = (rd_start_q == 64'd0) ? 32'd0 : rd_start_q[31:0] - 32'd1;
          seg_len_nxt   = rd_info_q.len;
          seg_syn_nxt   = rd_info_q.syn;
          seg_fin_nxt   = rd_info_q.fin;
          seg_retx_nxt  = 1'b1;
          ret_nxt       = S_DONE;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EMIT: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_nxt   = pend_r;
            out_v_nxt = 1'b1;
          end
          pend_nxt   = new_res;
          pend_v_nxt = 1'b1;
          nres_nxt   = nres_r + 6'd1;
          state_nxt  = ret_r;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt    = final_res;
          out_v_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      isn_r      <= 32'd0;
      rto_r      <= RTO_RESET;
      cap_r      <= CAP_RESET;
      next_r     <= 64'd0;
      acked_r    <= 64'd0;
      win_r      <= 16'd1;
      fin_sent_r <= 1'b0;
      elapsed_r  <= 32'd0;
      timeout_r  <= 32'd0;
      running_r  <= 1'b0;
      zws_r      <= 1'b0;
      retx_r     <= 16'd0;
      buf_r      <= 32'd0;
      ended_r    <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      qcount_r   <= '0;
      nres_r     <= 6'd0;
      acc_r      <= 16'd0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      next_r     <= next_nxt;
      acked_r    <= acked_nxt;
      win_r      <= win_nxt;
      fin_sent_r <= fin_sent_nxt;
      elapsed_r  <= elapsed_nxt;
      timeout_r  <= timeout_nxt;
      running_r  <= running_nxt;
      zws_r      <= zws_nxt;
      retx_r     <= retx_nxt;
      buf_r      <= buf_nxt;
      ended_r    <= ended_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      qcount_r   <= qcount_nxt;
      nres_r     <= nres_nxt;
      acc_r      <= acc_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ISN: isn_r <= cfg_wdata;
          CFG_RTO: rto_r <= cfg_wdata[15:0];
          CFG_CAP: cap_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    a_r         <= a_nxt;
    seg_start_r <= seg_start_nxt;
    seg_off_r   <= seg_off_nxt;
    seg_len_r   <= seg_len_nxt;
    seg_syn_r   <= seg_syn_nxt;
    seg_fin_r   <= seg_fin_nxt;
    seg_retx_r  <= seg_retx_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  // outstanding queue, one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_mem[tail_r] <= wr_start;
      info_mem[tail_r]  <= wr_info;
    end
    rd_start_q <= start_mem[head_r];
    rd_info_q  <= info_mem[head_r];
  end

endmodule

// ===== rtl/core/tcp_sender_window_retransmit.sv =====
// top level of the tcp sender window and retransmission engine
//
// channel   direction  handshake            contents
// in_*      input      in_valid / in_stall   one request word
// out_*     output     out_valid / out_stall one segment or status word
// cfg_*     input      cfg_wr_en            register write, no read-back
//
// one request at a time: every request passes the load and done steps, and its last word
// reaches out_* from the done step; a tick adds a tick step, each segment an emit step
// and a data segment a sizing step; a fill adds window, sizing and timer steps, and
// an ack adds compare and window steps, and retire steps via the registered queue read port
// a two-word input buffer and the output register let either side stall independently
// reset is synchronous and leaves the outstanding queue empty with no clearing pass
module tcp_sender_window_retransmit #(
  parameter int MAX_PAYLOAD = tsw_pkg::MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_ack_number,
  input  logic [15:0] in_receive_window,
  input  logic [15:0] in_elapsed_ms,
  input  logic [15:0] in_append_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_segment_valid,
  output logic [31:0] out_segment_seqno,
  output logic [31:0] out_payload_offset,
  output logic [10:0] out_payload_length,
  output logic        out_syn_bit,
  output logic        out_fin_bit,
  output logic        out_is_retransmission,
  output logic [31:0] out_in_flight_bytes,
  output logic [15:0] out_retransmit_count,
  output logic [15:0] out_accepted_count,
  output logic        out_last_result
);
  import tsw_pkg::*;

  logic  cmd_valid;
  logic  cmd_pop;
  cmd_t  cmd;
  res_t  res;
  stat_t stat;

  tsw_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_ack_number     (in_ack_number),
    .in_receive_window (in_receive_window),
    .in_elapsed_ms     (in_elapsed_ms),
    .in_append_count   (in_append_count),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop)
  );

  tsw_engine #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .stat      (stat)
  );

  assign out_segment_valid     = res.segment_valid;
  assign out_segment_seqno     = res.segment_seqno;
  assign out_payload_offset    = res.payload_offset;
  assign out_payload_length    = res.payload_length;
  assign out_syn_bit           = res.syn_bit;
  assign out_fin_bit           = res.fin_bit;
  assign out_is_retransmission = res.is_retransmission;
  assign out_in_flight_bytes   = res.in_flight_bytes;
  assign out_retransmit_count  = res.retransmit_count;
  assign out_accepted_count    = res.accepted_count;
  assign out_last_result       = res.last_result;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.queue_count <= 11'(QUEUE_DEPTH))
    else $error("outstanding queue count above depth");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_segment_valid |-> out_last_result)
    else $error("status word not final");

  a_retx_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_retransmission |-> out_segment_valid && out_last_result)
    else $error("retransmission not a single segment word");

  a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy && !cmd_valid |=> !in_stall)
    else $error("input stalled while engine idle and buffer empty");

endmodule
